### design/eqns_pkg.sv
`default_nettype none

package eqns_pkg;

  localparam int BOARD_SIZE_DEFAULT = 8;
  localparam int NUM_COLUMNS        = 8;
  localparam int FIELD_W            = 3;
  localparam int MOVES_W            = 4;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

endpackage

`default_nettype wire

### design/eight_queens_nearest_solution.sv
// search: the single place/backtrack step places or lifts one queen per cycle; once the
//   empty first level is left, the result beat is registered
// a new board is taken only while idle; busy stays high until the result beat
// reset: rst clears the sequencer, masks, level, best count and strobe; the receiver cannot stall
`default_nettype none

module eight_queens_nearest_solution
  import eqns_pkg::*;
#(
  parameter int BOARD_SIZE = BOARD_SIZE_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [FIELD_W-1:0] row_in_column_0,
  input  wire logic [FIELD_W-1:0] row_in_column_1,
  input  wire logic [FIELD_W-1:0] row_in_column_2,
  input  wire logic [FIELD_W-1:0] row_in_column_3,
  input  wire logic [FIELD_W-1:0] row_in_column_4,
  input  wire logic [FIELD_W-1:0] row_in_column_5,
  input  wire logic [FIELD_W-1:0] row_in_column_6,
  input  wire logic [FIELD_W-1:0] row_in_column_7,
  output logic                    done,
  output logic [MOVES_W-1:0]      fewest_moves
);

  localparam int RW = $clog2(BOARD_SIZE);
  localparam int CW = $clog2(BOARD_SIZE + 1);
  localparam int DW = 2 * BOARD_SIZE - 1;

  state_t                    state;
  logic [CW-1:0]             level;
  logic [CW-1:0]             cand;
  logic [BOARD_SIZE-1:0]     rows_used;
  logic [DW-1:0]             diag_used;
  logic [DW-1:0]             anti_used;
  logic [RW-1:0]             stack [BOARD_SIZE];
  logic [FIELD_W-1:0]        target [NUM_COLUMNS];
  logic [MOVES_W-1:0]        best;

  logic [DW-1:0]             diag_view;
  logic [DW-1:0]             anti_view;
  logic [CW-1:0]             anti_shift;
  logic [BOARD_SIZE-1:0]     free_rows;
  logic                      found;
  logic [RW-1:0]             pick_row;
  logic                      at_leaf;
  logic [CW-1:0]             pop_level;
  logic [RW-1:0]             top_row;
  logic [MOVES_W-1:0]        diff;
  logic [MOVES_W-1:0]        best_next;

  assign busy       = (state == ST_SEARCH);
  assign at_leaf    = (level == CW'(BOARD_SIZE));
  assign anti_shift = CW'(BOARD_SIZE - 1) - level;
  assign diag_view  = diag_used >> level;
  assign anti_view  = anti_used >> anti_shift;
  assign pop_level  = level - CW'(1);
  assign top_row    = stack[pop_level[RW-1:0]];

  // free rows at this level at or above the candidate row
  always_comb begin
    for (int i = 0; i < BOARD_SIZE; i++) begin
      free_rows[i] = ~(rows_used[i] | diag_view[i] | anti_view[i]) &&
                     (CW'(i) >= cand);
    end
  end

  always_comb begin
    found    = |free_rows;
    pick_row = '0;
    for (int i = BOARD_SIZE - 1; i >= 0; i--) begin
      if (free_rows[i]) begin
        pick_row = RW'(i);
      end
    end
  end

  always_comb begin
    diff = '0;
    for (int c = 0; c < BOARD_SIZE; c++) begin
      if (MOVES_W'(stack[c]) != MOVES_W'(target[c])) begin
        diff = diff + MOVES_W'(1);
      end
    end
  end

  always_comb begin
    best_next = best;
    if (at_leaf && (diff < best)) begin
      best_next = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      level     <= '0;
      cand      <= '0;
      rows_used <= '0;
      diag_used <= '0;
      anti_used <= '0;
      best      <= MOVES_W'(8);
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            target[0] <= row_in_column_0;
            target[1] <= row_in_column_1;
            target[2] <= row_in_column_2;
            target[3] <= row_in_column_3;
            target[4] <= row_in_column_4;
            target[5] <= row_in_column_5;
            target[6] <= row_in_column_6;
            target[7] <= row_in_column_7;
            rows_used <= '0;
            diag_used <= '0;
            anti_used <= '0;
            level     <= '0;
            cand      <= '0;
            best      <= MOVES_W'(BOARD_SIZE);
            state     <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (at_leaf || !found) begin
            best <= best_next;
            if (level == '0) begin
              fewest_moves <= best_next;
              done         <= 1'b1;
              state        <= ST_IDLE;
            end else begin
              // lift the queen of the level below and try its next row
              level     <= pop_level;
              cand      <= CW'(top_row) + CW'(1);
              rows_used <= rows_used & ~(BOARD_SIZE'(1) << top_row);
              diag_used <= diag_used & ~(DW'(1) << (DW'(top_row) + DW'(pop_level)));
              anti_used <= anti_used & ~(DW'(1) << (DW'(top_row) + DW'(BOARD_SIZE - 1)
                                                    - DW'(pop_level)));
            end
          end else begin
            stack[level[RW-1:0]] <= pick_row;
            level     <= level + CW'(1);
            cand      <= '0;
            rows_used <= rows_used | (BOARD_SIZE'(1) << pick_row);
            diag_used <= diag_used | (DW'(1) << (DW'(pick_row) + DW'(level)));
            anti_used <= anti_used | (DW'(1) << (DW'(pick_row) + DW'(BOARD_SIZE - 1)
                                                 - DW'(level)));
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
